// ===== rtl/core/lav_pkg.sv =====
// Shared constants and helpers for the look-at view matrix pipeline.
package lav_pkg;

  localparam int NORM_HI = 30;
  localparam int RSTEPS = 6;
  localparam int LSTEPS = 5;
  localparam int SHSTEPS = RSTEPS + LSTEPS;
  localparam int SQSTEPS = 32;

  localparam logic [1:0] COL_LAST = 2'd3;

  // Shift distance of one normalising step: right shifts first, then left shifts.
  function automatic int shift_amount(input int idx);
    if (idx < RSTEPS) begin
      return 32 >> idx;
    end
    return 16 >> (idx - RSTEPS);
  endfunction

endpackage

// ===== rtl/core/lav_norm.sv =====
// Pipelined vector normaliser: scale, square sum, square root and division.
module lav_norm
  import lav_pkg::*;
#(
  parameter int W = 33,
  parameter int FRAC_BITS = 16,
  parameter int PW = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [W-1:0]    vec_in [3],
  input  logic [PW-1:0]          side_in,
  output logic                   out_valid,
  output logic signed [FRAC_BITS+1:0] unit_out [3],
  output logic                   zero_out,
  output logic [PW-1:0]          side_out
);

  localparam int QW = FRAC_BITS + 2;
  localparam int DW = FRAC_BITS + 34;
  localparam int MP = PW + 4;

  logic [W-1:0]  mag_w [3];
  logic [63:0]   mag_a [3];
  logic [63:0]   mag_max;
  logic [2:0]    sgn;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_w[i] = vec_in[i][W-1] ? (~vec_in[i] + 1'b1) : vec_in[i];
      mag_a[i] = 64'(mag_w[i]);
      sgn[i] = vec_in[i][W-1];
    end
    mag_max = mag_a[0];
    if (mag_a[1] > mag_max) begin
      mag_max = mag_a[1];
    end
    if (mag_a[2] > mag_max) begin
      mag_max = mag_a[2];
    end
  end

  logic          sv    [SHSTEPS+1];
  logic [63:0]   sm    [SHSTEPS+1][3];
  logic [63:0]   sx    [SHSTEPS+1];
  logic [MP-1:0] smeta [SHSTEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sm[0][i] <= mag_a[i];
      end
      sx[0] <= mag_max;
      smeta[0] <= {side_in, sgn, mag_max == 64'd0};
    end
  end

  for (genvar j = 0; j < SHSTEPS; j++) begin : g_shift
    localparam int K = shift_amount(j);
    logic dosh;

    always_comb begin
      if (j < RSTEPS) begin
        dosh = (sx[j] >> (NORM_HI + K - 1)) != 64'd0;
      end else begin
        dosh = (sx[j] >> (NORM_HI - K)) == 64'd0;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j+1] <= 1'b0;
      end else if (en) begin
        sv[j+1] <= sv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        smeta[j+1] <= smeta[j];
        if (!dosh) begin
          sx[j+1] <= sx[j];
          for (int i = 0; i < 3; i++) begin
            sm[j+1][i] <= sm[j][i];
          end
        end else if (j < RSTEPS) begin
          sx[j+1] <= sx[j] >> K;
          for (int i = 0; i < 3; i++) begin
            sm[j+1][i] <= sm[j][i] >> K;
          end
        end else begin
          sx[j+1] <= sx[j] << K;
          for (int i = 0; i < 3; i++) begin
            sm[j+1][i] <= sm[j][i] << K;
          end
        end
      end
    end
  end

  logic          qv;
  logic [59:0]   sq [3];
  logic [29:0]   qm [3];
  logic [MP-1:0] qmeta;

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= 1'b0;
    end else if (en) begin
      qv <= sv[SHSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        qm[i] <= sm[SHSTEPS][i][29:0];
        sq[i] <= 60'(sm[SHSTEPS][i][29:0]) * 60'(sm[SHSTEPS][i][29:0]);
      end
      qmeta <= smeta[SHSTEPS];
    end
  end

  logic          rv    [SQSTEPS+1];
  logic [63:0]   rx    [SQSTEPS+1];
  logic [63:0]   rr    [SQSTEPS+1];
  logic [29:0]   rm    [SQSTEPS+1][3];
  logic [MP-1:0] rmeta [SQSTEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else if (en) begin
      rv[0] <= qv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx[0] <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
      rr[0] <= 64'd0;
      for (int i = 0; i < 3; i++) begin
        rm[0][i] <= qm[i];
      end
      rmeta[0] <= qmeta;
    end
  end

  for (genvar s = 0; s < SQSTEPS; s++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * s);
    logic [63:0] trial;

    assign trial = rr[s] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        rv[s+1] <= 1'b0;
      end else if (en) begin
        rv[s+1] <= rv[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rx[s] >= trial) begin
          rx[s+1] <= rx[s] - trial;
          rr[s+1] <= (rr[s] >> 1) + BIT;
        end else begin
          rx[s+1] <= rx[s];
          rr[s+1] <= rr[s] >> 1;
        end
        for (int i = 0; i < 3; i++) begin
          rm[s+1][i] <= rm[s][i];
        end
        rmeta[s+1] <= rmeta[s];
      end
    end
  end

  logic          dv    [QW+1];
  logic [DW-1:0] drem  [QW+1][3];
  logic [QW-1:0] dq    [QW+1][3];
  logic [30:0]   dlen  [QW+1];
  logic [MP-1:0] dmeta [QW+1];
  logic [30:0]   len;

  assign len = rr[SQSTEPS][30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= rv[SQSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= ({{(DW-30){1'b0}}, rm[SQSTEPS][i]} << FRAC_BITS)
                      + {{(DW-31){1'b0}}, len >> 1};
        dq[0][i] <= '0;
      end
      dlen[0] <= len;
      dmeta[0] <= rmeta[SQSTEPS];
    end
  end

  for (genvar b = 0; b < QW; b++) begin : g_div
    localparam int B = QW - 1 - b;
    localparam logic [QW-1:0] QBIT = {{(QW-1){1'b0}}, 1'b1} << B;
    logic [DW-1:0] dsub;

    assign dsub = {{(DW-31){1'b0}}, dlen[b]} << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[b+1] <= 1'b0;
      end else if (en) begin
        dv[b+1] <= dv[b];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (drem[b][i] >= dsub) begin
            drem[b+1][i] <= drem[b][i] - dsub;
            dq[b+1][i] <= dq[b][i] | QBIT;
          end else begin
            drem[b+1][i] <= drem[b][i];
            dq[b+1][i] <= dq[b][i];
          end
        end
        dlen[b+1] <= dlen[b];
        dmeta[b+1] <= dmeta[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dmeta[QW][0]) begin
          unit_out[i] <= '0;
        end else if (dmeta[QW][1+i]) begin
          unit_out[i] <= ~dq[QW][i] + 1'b1;
        end else begin
          unit_out[i] <= dq[QW][i];
        end
      end
      zero_out <= dmeta[QW][0];
      side_out <= dmeta[QW][MP-1:4];
    end
  end

endmodule

// ===== rtl/core/look_at_view_matrix_top.sv =====
// Top level of the fixed-point look-at view matrix pipeline.
//
// A request carries eye, target and up vectors plus an inverse flag on a
// valid/ready input channel. Each request yields four column results on a
// valid/ready output channel, columns 0 to 3 in order, the last marked by
// last_column; degenerate is the same on all four.
// The path from acceptance to the first column holds three normalisers of
// FRAC_BITS + 50 stages each, set by the 32-step square root and the
// quotient-bit division, plus cross product, dot product and rounding stages.
// Throughput is set by the four output columns: once the pipeline is full,
// a new request enters as the last column of the previous one leaves, so
// columns stream without gaps while the receiver takes them.
// Reset clears every valid bit and the column counter; data is not reset.
// If the receiver stalls, empty stages fill; with a result waiting, the
// whole pipeline holds, in_ready falls and nothing is lost or repeated.
module look_at_view_matrix_top
  import lav_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic signed [31:0] up_x,
  input  logic signed [31:0] up_y,
  input  logic signed [31:0] up_z,
  input  logic               want_inverse,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         column_index,
  output logic signed [31:0] entry_row0,
  output logic signed [31:0] entry_row1,
  output logic signed [31:0] entry_row2,
  output logic               last_column,
  output logic               degenerate
);

  localparam int UW = FRAC_BITS + 2;
  localparam int PW = UW + 32;
  localparam int C1W = PW + 1;
  localparam int C2W = 2 * UW + 1;
  localparam int SW = PW + 2;
  localparam int S1W = 193;
  localparam int S2W = 98 + 3 * UW;
  localparam int S3W = 98 + 6 * UW;
  localparam logic [SW-1:0] HALF = {{(SW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic [SW-1:0] NEG_LIM = {{(SW-1){1'b0}}, 1'b1} << 31;
  localparam logic [SW-1:0] POS_LIM = NEG_LIM - {{(SW-1){1'b0}}, 1'b1};

  logic en;

  logic                gv;
  logic signed [32:0]  gz [3];
  logic [S1W-1:0]      gside;

  always_ff @(posedge clk) begin
    if (rst) begin
      gv <= 1'b0;
    end else if (en) begin
      gv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gz[0] <= 33'(target_x) - 33'(eye_x);
      gz[1] <= 33'(target_y) - 33'(eye_y);
      gz[2] <= 33'(target_z) - 33'(eye_z);
      gside <= {want_inverse, up_z, up_y, up_x, eye_z, eye_y, eye_x};
    end
  end

  logic                n1v, n1z;
  logic signed [UW-1:0] fwd1 [3];
  logic [S1W-1:0]      n1side;

  lav_norm #(.W(33), .FRAC_BITS(FRAC_BITS), .PW(S1W)) u_norm_fwd (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (gv),
    .vec_in    (gz),
    .side_in   (gside),
    .out_valid (n1v),
    .unit_out  (fwd1),
    .zero_out  (n1z),
    .side_out  (n1side)
  );

  logic signed [31:0] up1 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      up1[i] = $signed(n1side[96 + 32 * i +: 32]);
    end
  end

  logic                 c1av, c1adeg;
  logic signed [PW-1:0] c1p [6];
  logic signed [UW-1:0] c1f [3];
  logic [96:0]          c1keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1av <= 1'b0;
    end else if (en) begin
      c1av <= n1v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1p[0] <= PW'(fwd1[1]) * PW'(up1[2]);
      c1p[1] <= PW'(fwd1[2]) * PW'(up1[1]);
      c1p[2] <= PW'(fwd1[2]) * PW'(up1[0]);
      c1p[3] <= PW'(fwd1[0]) * PW'(up1[2]);
      c1p[4] <= PW'(fwd1[0]) * PW'(up1[1]);
      c1p[5] <= PW'(fwd1[1]) * PW'(up1[0]);
      for (int i = 0; i < 3; i++) begin
        c1f[i] <= fwd1[i];
      end
      c1keep <= {n1side[192], n1side[95:0]};
      c1adeg <= n1z;
    end
  end

  logic                  c1bv;
  logic signed [C1W-1:0] c1d [3];
  logic [S2W-1:0]        c1side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1bv <= 1'b0;
    end else if (en) begin
      c1bv <= c1av;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1d[0] <= C1W'(c1p[0]) - C1W'(c1p[1]);
      c1d[1] <= C1W'(c1p[2]) - C1W'(c1p[3]);
      c1d[2] <= C1W'(c1p[4]) - C1W'(c1p[5]);
      c1side <= {c1adeg, c1keep, c1f[2], c1f[1], c1f[0]};
    end
  end

  logic                 n2v, n2z;
  logic signed [UW-1:0] rgt2 [3];
  logic [S2W-1:0]       n2side;

  lav_norm #(.W(C1W), .FRAC_BITS(FRAC_BITS), .PW(S2W)) u_norm_right (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c1bv),
    .vec_in    (c1d),
    .side_in   (c1side),
    .out_valid (n2v),
    .unit_out  (rgt2),
    .zero_out  (n2z),
    .side_out  (n2side)
  );

  logic signed [UW-1:0] fwd2 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fwd2[i] = $signed(n2side[UW * i +: UW]);
    end
  end

  logic                     c2av, c2adeg;
  logic signed [2*UW-1:0]   c2p [6];
  logic signed [UW-1:0]     c2r [3];
  logic signed [UW-1:0]     c2f [3];
  logic [96:0]              c2keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2av <= 1'b0;
    end else if (en) begin
      c2av <= n2v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2p[0] <= (2*UW)'(rgt2[1]) * (2*UW)'(fwd2[2]);
      c2p[1] <= (2*UW)'(rgt2[2]) * (2*UW)'(fwd2[1]);
      c2p[2] <= (2*UW)'(rgt2[2]) * (2*UW)'(fwd2[0]);
      c2p[3] <= (2*UW)'(rgt2[0]) * (2*UW)'(fwd2[2]);
      c2p[4] <= (2*UW)'(rgt2[0]) * (2*UW)'(fwd2[1]);
      c2p[5] <= (2*UW)'(rgt2[1]) * (2*UW)'(fwd2[0]);
      for (int i = 0; i < 3; i++) begin
        c2r[i] <= rgt2[i];
        c2f[i] <= fwd2[i];
      end
      c2keep <= n2side[3 * UW +: 97];
      c2adeg <= n2side[S2W-1] | n2z;
    end
  end

  logic                  c2bv;
  logic signed [C2W-1:0] c2d [3];
  logic [S3W-1:0]        c2side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2bv <= 1'b0;
    end else if (en) begin
      c2bv <= c2av;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2d[0] <= C2W'(c2p[0]) - C2W'(c2p[1]);
      c2d[1] <= C2W'(c2p[2]) - C2W'(c2p[3]);
      c2d[2] <= C2W'(c2p[4]) - C2W'(c2p[5]);
      c2side <= {c2adeg, c2keep, c2r[2], c2r[1], c2r[0], c2f[2], c2f[1], c2f[0]};
    end
  end

  logic                 n3v, n3z;
  logic signed [UW-1:0] top3 [3];
  logic [S3W-1:0]       n3side;

  lav_norm #(.W(C2W), .FRAC_BITS(FRAC_BITS), .PW(S3W)) u_norm_top (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c2bv),
    .vec_in    (c2d),
    .side_in   (c2side),
    .out_valid (n3v),
    .unit_out  (top3),
    .zero_out  (n3z),
    .side_out  (n3side)
  );

  logic                 kv    [3];
  logic signed [UW-1:0] kr    [3][3];
  logic signed [UW-1:0] kt    [3][3];
  logic signed [UW-1:0] kf    [3][3];
  logic [96:0]          kkeep [3];
  logic                 kdeg  [3];
  logic signed [31:0]   eye3  [3];
  logic signed [PW-1:0] pp    [3][3];
  logic signed [SW-1:0] ss    [3];
  logic [SW-1:0]        smag  [3];
  logic [SW-1:0]        rmag  [3];
  logic                 rneg  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eye3[i] = $signed(n3side[6 * UW + 32 * i +: 32]);
      smag[i] = ss[i][SW-1] ? (~ss[i] + 1'b1) : ss[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 3; s++) begin
        kv[s] <= 1'b0;
      end
    end else if (en) begin
      kv[0] <= n3v;
      kv[1] <= kv[0];
      kv[2] <= kv[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        kf[0][i] <= $signed(n3side[UW * i +: UW]);
        kr[0][i] <= $signed(n3side[3 * UW + UW * i +: UW]);
        kt[0][i] <= top3[i];
        pp[0][i] <= PW'($signed(n3side[3 * UW + UW * i +: UW])) * PW'(eye3[i]);
        pp[1][i] <= PW'(top3[i]) * PW'(eye3[i]);
        pp[2][i] <= PW'($signed(n3side[UW * i +: UW])) * PW'(eye3[i]);
      end
      kkeep[0] <= n3side[6 * UW +: 97];
      kdeg[0] <= n3side[S3W-1] | n3z;

      ss[0] <= -(SW'(pp[0][0]) + SW'(pp[0][1]) + SW'(pp[0][2]));
      ss[1] <= -(SW'(pp[1][0]) + SW'(pp[1][1]) + SW'(pp[1][2]));
      ss[2] <= SW'(pp[2][0]) + SW'(pp[2][1]) + SW'(pp[2][2]);

      for (int i = 0; i < 3; i++) begin
        rneg[i] <= ss[i][SW-1];
        rmag[i] <= (smag[i] + HALF) >> FRAC_BITS;
      end

      for (int s = 1; s < 3; s++) begin
        for (int i = 0; i < 3; i++) begin
          kr[s][i] <= kr[s-1][i];
          kt[s][i] <= kt[s-1][i];
          kf[s][i] <= kf[s-1][i];
        end
        kkeep[s] <= kkeep[s-1];
        kdeg[s] <= kdeg[s-1];
      end
    end
  end

  logic signed [31:0] trans    [3];
  logic signed [31:0] col_next [4][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!rneg[i]) begin
        trans[i] = (rmag[i] > POS_LIM) ? 32'sh7FFF_FFFF : $signed(rmag[i][31:0]);
      end else begin
        trans[i] = (rmag[i] > NEG_LIM) ? 32'sh8000_0000
                                       : $signed(~rmag[i][31:0] + 32'd1);
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (kkeep[2][96]) begin
        col_next[0][i] = 32'(kr[2][i]);
        col_next[1][i] = 32'(kt[2][i]);
        col_next[2][i] = -32'(kf[2][i]);
        col_next[3][i] = $signed(kkeep[2][32 * i +: 32]);
      end else begin
        col_next[i][0] = 32'(kr[2][i]);
        col_next[i][1] = 32'(kt[2][i]);
        col_next[i][2] = -32'(kf[2][i]);
        col_next[3][i] = trans[i];
      end
    end
  end

  logic               hv, hdeg, load_ok;
  logic [1:0]         cnt;
  logic signed [31:0] hcol [4][3];

  assign load_ok = !hv || (out_ready && cnt == COL_LAST);
  assign en = load_ok || !kv[2];
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (hv && out_ready) begin
        cnt <= cnt + 2'd1;
      end
      if (load_ok) begin
        hv <= kv[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && kv[2]) begin
      hcol <= col_next;
      hdeg <= kdeg[2];
    end
  end

  assign out_valid = hv;
  assign column_index = cnt;
  assign entry_row0 = hcol[cnt][0];
  assign entry_row1 = hcol[cnt][1];
  assign entry_row2 = hcol[cnt][2];
  assign last_column = cnt == COL_LAST;
  assign degenerate = hdeg;

endmodule
